### design/mrtc_pkg.sv
// mrtc_pkg: shared types and codes for the message retry timeout controller
// request/result payload structs, register file, controller state, kind codes
// no dependencies
package mrtc_pkg;

	localparam int unsigned LEN_EXTRA = 3;

	// request kinds
	localparam logic [1:0] FUNC_REQ    = 2'd0;
	localparam logic [1:0] FUNC_STATUS = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// register indexes on the configuration port
	localparam logic [2:0] REG_LOCAL_TRY_LIMIT      = 3'd0;
	localparam logic [2:0] REG_REMOTE_TRY_LIMIT     = 3'd1;
	localparam logic [2:0] REG_LOCAL_RESPONSE_WAIT  = 3'd2;
	localparam logic [2:0] REG_REMOTE_RESPONSE_WAIT = 3'd3;
	localparam logic [2:0] REG_LOCAL_RETRY_DELAY    = 3'd4;
	localparam logic [2:0] REG_REMOTE_RETRY_DELAY   = 3'd5;
	localparam logic [2:0] REG_SUCCESS_CODE         = 3'd6;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'b001,
		PH_SEND  = 3'b010,
		PH_PAUSE = 3'b100
	} phase_t;

	typedef struct packed {
		logic [1:0] func;
		logic       to_local_chip;
		logic [7:0] length_byte;
		logic [7:0] status_byte;
	} in_t;

	typedef struct packed {
		logic       accepted;
		logic       refused_busy;
		logic       send_now;
		logic [8:0] send_length;
		logic       timed_out;
		logic       timeout_to_local;
		logic       busy_res;
	} out_t;

	typedef struct packed {
		logic [7:0]  local_try_limit;
		logic [7:0]  remote_try_limit;
		logic [15:0] local_response_wait;
		logic [15:0] remote_response_wait;
		logic [15:0] local_retry_delay;
		logic [15:0] remote_retry_delay;
		logic [7:0]  success_code;
	} cfg_t;

	typedef struct packed {
		phase_t      phase;
		logic        dest_local;
		logic [7:0]  tries_done;
		logic [15:0] ticks_left;
		logic [7:0]  stored_length;
	} state_t;

endpackage

### design/mrtc_step.sv
// mrtc_step: next-state and result logic for one request
// purely combinational; depends on mrtc_pkg
module mrtc_step (
	input  mrtc_pkg::cfg_t   cfg,
	input  mrtc_pkg::state_t cur,
	input  mrtc_pkg::in_t    req,
	output mrtc_pkg::state_t nxt,
	output mrtc_pkg::out_t   res
);
	import mrtc_pkg::*;

	logic [7:0]  tries_inc;
	logic [7:0]  limit;
	logic [15:0] wait_cur;
	logic [15:0] wait_new;
	logic [15:0] delay_cur;
	logic        send;

	always_comb begin
		tries_inc = (cur.tries_done != 8'hFF) ? cur.tries_done + 8'd1 : cur.tries_done;
		limit     = cur.dest_local ? cfg.local_try_limit : cfg.remote_try_limit;
		wait_cur  = cur.dest_local ? cfg.local_response_wait : cfg.remote_response_wait;
		delay_cur = cur.dest_local ? cfg.local_retry_delay : cfg.remote_retry_delay;
		wait_new  = req.to_local_chip ? cfg.local_response_wait : cfg.remote_response_wait;
	end

	always_comb begin
		nxt  = cur;
		res  = '0;
		send = 1'b0;
		unique case (req.func)
			FUNC_REQ: begin
				if (cur.phase != PH_IDLE) begin
					res.refused_busy = 1'b1;
				end else begin
					res.accepted      = 1'b1;
					nxt.dest_local    = req.to_local_chip;
					nxt.stored_length = req.length_byte;
					nxt.tries_done    = '0;
					nxt.phase         = PH_SEND;
					nxt.ticks_left    = wait_new;
					send              = 1'b1;
				end
			end
			FUNC_STATUS: begin
				if (cur.phase == PH_SEND) begin
					if (req.status_byte == cfg.success_code) begin
						nxt.phase      = PH_IDLE;
						nxt.tries_done = '0;
						nxt.ticks_left = '0;
					end else if (tries_inc < limit) begin
						// nak with tries left: pause before the resend
						nxt.tries_done = tries_inc;
						nxt.phase      = PH_PAUSE;
						nxt.ticks_left = delay_cur;
					end else begin
						// nak on the last try ends silently
						nxt.phase      = PH_IDLE;
						nxt.tries_done = '0;
						nxt.ticks_left = '0;
					end
				end
			end
			FUNC_TICK: begin
				if (cur.phase != PH_IDLE) begin
					if (cur.ticks_left > 16'd1) begin
						nxt.ticks_left = cur.ticks_left - 16'd1;
					end else if (cur.phase == PH_PAUSE) begin
						nxt.phase      = PH_SEND;
						nxt.ticks_left = wait_cur;
						send           = 1'b1;
					end else if (tries_inc < limit) begin
						// response timeout, resend at once
						nxt.tries_done = tries_inc;
						nxt.ticks_left = wait_cur;
						send           = 1'b1;
					end else begin
						res.timed_out        = 1'b1;
						res.timeout_to_local = cur.dest_local;
						nxt.phase            = PH_IDLE;
						nxt.tries_done       = '0;
						nxt.ticks_left       = '0;
					end
				end
			end
			default: begin
			end
		endcase
		res.send_now    = send;
		res.send_length = send ? {1'b0, nxt.stored_length} + 9'(LEN_EXTRA) : 9'd0;
		res.busy_res    = (nxt.phase != PH_IDLE);
	end

endmodule

### design/message_retry_timeout_controller_core.sv
// message_retry_timeout_controller_core: stop-and-wait retry controller top level
// input register, step logic, result register and register file; uses mrtc_pkg, mrtc_step
//
//  channel  | signals                        | direction | payload
//  ---------+--------------------------------+-----------+---------------------
//  in       | in_valid, in_stall, in_data    | into core | request, tick, status
//  out      | out_valid, out_stall, out_data | out       | one result per request
//  cfg      | cfg_we, cfg_index, cfg_data    | into core | register writes
//
// one request per clock sustained while the result is not stalled; a request passes
// through the input register, then step logic into the result register
// arst_n clears the controller to idle and loads register reset values
// a stalled result holds; the input register still moves when the result
// register is empty or being taken, so in_stall only rises under out_stall
module message_retry_timeout_controller_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  mrtc_pkg::in_t                         in_data,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output mrtc_pkg::out_t                        out_data,
	input  logic                                  cfg_we,
	input  logic [mrtc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [mrtc_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import mrtc_pkg::*;

	// register file
	cfg_t   cfg_q;

	// input stage
	logic   valid_s1;
	in_t    req_s1;

	// controller state, updated as the request leaves the input stage
	state_t state_q;
	state_t state_nxt;
	out_t   res_nxt;

	// result register
	logic   out_valid_q;
	out_t   out_data_q;

	logic   advance;

	// the input stage empties whenever the result register can take its result
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_try_limit      <= 8'd3;
			cfg_q.remote_try_limit     <= 8'd3;
			cfg_q.local_response_wait  <= 16'd100;
			cfg_q.remote_response_wait <= 16'd500;
			cfg_q.local_retry_delay    <= 16'd50;
			cfg_q.remote_retry_delay   <= 16'd200;
			cfg_q.success_code         <= 8'd0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_TRY_LIMIT:      cfg_q.local_try_limit      <= cfg_data[7:0];
				REG_REMOTE_TRY_LIMIT:     cfg_q.remote_try_limit     <= cfg_data[7:0];
				REG_LOCAL_RESPONSE_WAIT:  cfg_q.local_response_wait  <= cfg_data;
				REG_REMOTE_RESPONSE_WAIT: cfg_q.remote_response_wait <= cfg_data;
				REG_LOCAL_RETRY_DELAY:    cfg_q.local_retry_delay    <= cfg_data;
				REG_REMOTE_RETRY_DELAY:   cfg_q.remote_retry_delay   <= cfg_data;
				REG_SUCCESS_CODE:         cfg_q.success_code         <= cfg_data[7:0];
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1 <= in_data;
		end
	end

	mrtc_step u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.req (req_s1),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	// controller state moves only when a request is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= PH_IDLE;
			state_q.dest_local    <= 1'b0;
			state_q.tries_done    <= '0;
			state_q.ticks_left    <= '0;
			state_q.stored_length <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_data_q <= res_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
